[src/ctcgd_pkg.sv]
// Shared widths, constants and register indexes for the greedy CTC decoder.
// No dependencies; used by every module in src.
package ctcgd_pkg;

   localparam int SCORE_W = 17;
   localparam int TOKEN_W = 13;
   localparam int MEAN_W = 17;
   localparam int LIMIT_W = 14;

   localparam int ONE_Q16_INT = 65536;
   localparam logic [SCORE_W-1:0] ONE_Q16 = 17'h10000;

   localparam int MAX_CLASSES_DEF = 8192;
   localparam int MAX_STEPS_DEF = 512;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 48;
   localparam int TOKEN_LSB = 0;
   localparam int TSCORE_LSB = TOKEN_LSB + TOKEN_W;
   localparam int MEAN_LSB = TSCORE_LSB + SCORE_W;
   localparam int RSP_PAD_W = RSP_TDATA_W - (MEAN_LSB + MEAN_W);

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 14;
   localparam logic [CSR_IDX_W-1:0] CSR_TOKEN_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLLAPSE = 2'd1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd8192;

endpackage

[src/ctcgd_div.sv]
// Bit-serial restoring divider for the rounded line mean: one quotient bit per cycle.
// Depends on ctcgd_pkg for default widths.
module ctcgd_div import ctcgd_pkg::*; #(
   parameter int SUM_W = $clog2(ONE_Q16_INT * MAX_STEPS_DEF + 1),
   parameter int CNT_W = $clog2(MAX_STEPS_DEF + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SUM_W-1:0]   sum,
   input  logic [CNT_W-1:0]   count,
   output logic               done,
   output logic [SUM_W:0]     quotient
);

   localparam int DIV_W = SUM_W + 1;
   localparam int REM_W = CNT_W + 1;
   localparam int ITER_W = $clog2(DIV_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [DIV_W-1:0]  num_ff, num_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  rem_dif;
   logic              ge;

   always_comb begin
      rem_sh = {rem_ff, num_ff[DIV_W-1]};
      ge = rem_sh >= {1'b0, dvs_ff};
      rem_dif = rem_sh - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = ITER_W'(DIV_W);
         num_in = DIV_W'(sum) + DIV_W'(count >> 1);
         rem_in = '0;
         dvs_in = count;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_W-2:0], ge};
         rem_in = ge ? rem_dif[CNT_W-1:0] : rem_sh[CNT_W-1:0];
         iter_in = iter_ff - 1'b1;
         if (iter_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quotient = num_ff;

endmodule

[src/ctc_greedy_decoder.sv]
// Greedy CTC decoder: per-step argmax, blank/repeat drop, token output, line mean score.
// A token word is on rsp in the cycle after its step-ending req word; the summary word
// follows an end_of_line word through ST_START, ST_DIV (mean divider in ctcgd_div), ST_SUM.
// Throughput: one req word per cycle within a line while rsp is not stalled; after
// end_of_line req_tready stays low until ST_SUM hands the summary word to rsp.
// Reset: synchronous, active high; clears line state, token_limit to 8192, collapse to 1.
module ctc_greedy_decoder import ctcgd_pkg::*; #(
   parameter int MAX_CLASSES = MAX_CLASSES_DEF,
   parameter int MAX_STEPS = MAX_STEPS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // score[16:0], zero pad
   input  logic                   req_tuser,   // end_of_step
   input  logic                   req_tlast,   // end_of_line
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // token[12:0], token_score, mean_score, pad
   output logic                   rsp_tuser,   // is_summary
   output logic                   rsp_tlast,   // last
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int IDX_W = $clog2(MAX_CLASSES);
   localparam int CNT_W = $clog2(MAX_STEPS + 1);
   localparam int SUM_W = $clog2(ONE_Q16_INT * MAX_STEPS + 1);

   localparam logic [1:0] ST_RUN = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_DIV = 2'd2;
   localparam logic [1:0] ST_SUM = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               collapse_ff, collapse_in;
   logic [SCORE_W-1:0] best_sc_ff, best_sc_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [IDX_W-1:0]   prev_idx_ff, prev_idx_in;
   logic               prev_vld_ff, prev_vld_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [MEAN_W-1:0]  mean_ff, mean_in;
   logic               out_vld_ff, out_vld_in;
   logic [TOKEN_W-1:0] out_token_ff, out_token_in;
   logic [SCORE_W-1:0] out_tsc_ff, out_tsc_in;
   logic [MEAN_W-1:0]  out_mean_ff, out_mean_in;
   logic               out_summ_ff, out_summ_in;
   logic               out_last_ff, out_last_in;

   logic [SCORE_W-1:0] req_score;
   logic [SCORE_W-1:0] sc_clamp;
   logic [SCORE_W-1:0] cur_sc;
   logic [IDX_W-1:0]   cur_idx;
   logic [31:0]        idx_ext;
   logic               out_free;
   logic               accept;
   logic               take;
   logic               drop;
   logic               div_start;
   logic               div_done;
   logic [SUM_W:0]     div_q;

   ctcgd_div #(
      .SUM_W(SUM_W),
      .CNT_W(CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .sum      (sum_ff),
      .count    (cnt_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      req_score = req_tdata[SCORE_W-1:0];
      out_free = !out_vld_ff || rsp_tready;
      req_tready = (state_ff == ST_RUN) && out_free;
      accept = req_tvalid && req_tready;
      div_start = (state_ff == ST_START);
      sc_clamp = (req_score > ONE_Q16) ? ONE_Q16 : req_score;
      take = (pos_ff == '0) || (sc_clamp > best_sc_ff);
      cur_sc = take ? sc_clamp : best_sc_ff;
      cur_idx = take ? pos_ff : best_idx_ff;
      idx_ext = 32'(cur_idx);
      drop = (cur_idx == '0) || (collapse_ff && prev_vld_ff && (cur_idx == prev_idx_ff));

      state_in = state_ff;
      limit_in = limit_ff;
      collapse_in = collapse_ff;
      best_sc_in = best_sc_ff;
      best_idx_in = best_idx_ff;
      pos_in = pos_ff;
      prev_idx_in = prev_idx_ff;
      prev_vld_in = prev_vld_ff;
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      mean_in = mean_ff;
      out_vld_in = out_vld_ff && !rsp_tready;
      out_token_in = out_token_ff;
      out_tsc_in = out_tsc_ff;
      out_mean_in = out_mean_ff;
      out_summ_in = out_summ_ff;
      out_last_in = out_last_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_TOKEN_LIMIT: limit_in = csr_data[LIMIT_W-1:0];
            CSR_COLLAPSE:    collapse_in = csr_data[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_RUN: begin
            if (accept) begin
               best_sc_in = cur_sc;
               best_idx_in = cur_idx;
               if (pos_ff < IDX_W'(MAX_CLASSES - 1)) begin
                  pos_in = pos_ff + 1'b1;
               end
               if (req_tuser || req_tlast) begin
                  best_sc_in = '0;
                  best_idx_in = '0;
                  pos_in = '0;
                  prev_idx_in = cur_idx;
                  prev_vld_in = 1'b1;
                  if (!drop) begin
                     if (cnt_ff < CNT_W'(MAX_STEPS)) begin
                        sum_in = sum_ff + SUM_W'(cur_sc);
                        cnt_in = cnt_ff + 1'b1;
                     end
                     if (idx_ext < 32'(limit_ff)) begin
                        out_vld_in = 1'b1;
                        out_token_in = idx_ext[TOKEN_W-1:0];
                        out_tsc_in = cur_sc;
                        out_mean_in = '0;
                        out_summ_in = 1'b0;
                        out_last_in = 1'b0;
                     end
                  end
               end
               if (req_tlast) begin
                  prev_idx_in = '0;
                  prev_vld_in = 1'b0;
                  state_in = ST_START;
               end
            end
         end
         ST_START: state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) begin
               mean_in = (cnt_ff == '0) ? '0 : div_q[MEAN_W-1:0];
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               out_token_in = '0;
               out_tsc_in = '0;
               out_mean_in = mean_ff;
               out_summ_in = 1'b1;
               out_last_in = 1'b1;
               sum_in = '0;
               cnt_in = '0;
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         limit_ff <= LIMIT_RESET;
         collapse_ff <= 1'b1;
         best_sc_ff <= '0;
         best_idx_ff <= '0;
         pos_ff <= '0;
         prev_idx_ff <= '0;
         prev_vld_ff <= 1'b0;
         sum_ff <= '0;
         cnt_ff <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         limit_ff <= limit_in;
         collapse_ff <= collapse_in;
         best_sc_ff <= best_sc_in;
         best_idx_ff <= best_idx_in;
         pos_ff <= pos_in;
         prev_idx_ff <= prev_idx_in;
         prev_vld_ff <= prev_vld_in;
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      mean_ff <= mean_in;
      out_token_ff <= out_token_in;
      out_tsc_ff <= out_tsc_in;
      out_mean_ff <= out_mean_in;
      out_summ_ff <= out_summ_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, out_mean_ff, out_tsc_ff, out_token_ff};
   assign rsp_tuser = out_summ_ff;
   assign rsp_tlast = out_last_ff;
   assign csr_ready = 1'b1;

endmodule

[src/ctcgd_checker.sv]
// Port-level checks on the decoder's result channel, bound to the top level.
// Depends on ctcgd_pkg for field positions.
module ctcgd_checker import ctcgd_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,   // token[12:0], token_score, mean_score, pad
   input logic                   rsp_tuser,   // is_summary
   input logic                   rsp_tlast    // last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == rsp_tlast)
      else $error("summary word and last flag disagree");

   a_summary_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[MEAN_LSB-1:0] == '0)
      else $error("summary word carries token fields");

   a_token_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         rsp_tdata[MEAN_LSB +: MEAN_W] == '0 &&
         rsp_tdata[TSCORE_LSB +: SCORE_W] <= ONE_Q16 &&
         rsp_tdata[TOKEN_LSB +: TOKEN_W] != '0)
      else $error("token word out of range");

endmodule

bind ctc_greedy_decoder ctcgd_checker u_ctcgd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
